// ===== design/htps_pkg.sv =====
// shared types, constants and widths for the heater thermal plant step block
package htps_pkg;

    localparam int TABLE_POINTS = 8;
    localparam int IDX_W = $clog2(TABLE_POINTS);
    localparam int CNT_W = $clog2(TABLE_POINTS + 1);

    localparam int TEMP_W = 20;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 20'sd524287;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -20'sd524288;

    localparam logic [15:0] ROOM_TEMP_RST = 16'd6400;
    localparam logic [31:0] INV_CAP_RST   = 32'd113092000;
    localparam logic [31:0] DFLT_LOSS_RST = 32'd14680;

    // milliseconds per second
    localparam logic [31:0] MS_PER_S = 32'd1000;

    // input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_ROOM_TEMP = 2'd0;
    localparam logic [1:0] REG_INV_CAP   = 2'd1;
    localparam logic [1:0] REG_DFLT_LOSS = 2'd2;

    // shared arithmetic unit widths
    localparam int ALU_A_W   = 62;
    localparam int MUL_A_W   = 52;
    localparam int ALU_B_W   = 32;
    localparam int DIGIT_W   = 16;
    localparam int PROD_W    = MUL_A_W + ALU_B_W;
    localparam int DIV_D_W   = 17;
    localparam int MUL_STEPS = ALU_B_W / DIGIT_W;
    localparam int DIV_STEPS = ALU_A_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic                 start;
        alu_op_t              op;
        logic [ALU_A_W-1:0]   a;
        logic [ALU_B_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic                 done;
        logic [PROD_W-1:0]    prod;
        logic [ALU_A_W-1:0]   quot;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH0,
        S_SRCH1,
        S_SCAN,
        S_RDA,
        S_RDB,
        S_MUL1,
        S_DIV1,
        S_HEAT,
        S_MUL2,
        S_MUL3,
        S_DIV2,
        S_MUL4
    } state_t;

endpackage

// ===== design/htps_table.sv =====
// coefficient table: point temperatures, coefficients and fill count
module htps_table
    import htps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [2:0]       entry_index,
    input  logic [16:0]      entry_temp,
    input  logic [31:0]      entry_coeff,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [16:0]      rd_temp,
    output logic [31:0]      rd_coeff,
    output logic [CNT_W-1:0] count
);

    logic [16:0]      temp_reg  [TABLE_POINTS];
    logic [31:0]      coeff_reg [TABLE_POINTS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_range;

    assign in_range = (32'(entry_index) < TABLE_POINTS);

    always_comb
    begin
        count_next = count_reg;
        if (wr && in_range)
        begin
            count_next = CNT_W'(32'(entry_index) + 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // no reset: entries are undefined until loaded
    always_ff @(posedge clk)
    begin
        if (wr && in_range)
        begin
            temp_reg[IDX_W'(entry_index)]  <= entry_temp;
            coeff_reg[IDX_W'(entry_index)] <= entry_coeff;
        end
    end

    assign rd_temp  = temp_reg[rd_idx];
    assign rd_coeff = coeff_reg[rd_idx];
    assign count    = count_reg;

endmodule

// ===== design/htps_alu.sv =====
// shared multi-cycle unit: 16-bit-digit multiply and radix-4 restoring divide
module htps_alu
    import htps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    alu_op_t             op_reg, op_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [ALU_A_W-1:0]  a_reg, a_next;
    logic [ALU_B_W-1:0]  b_reg, b_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [DIV_D_W-1:0]  rem_reg, rem_next;
    logic [MUL_A_W+DIGIT_W-1:0] part_prod;

    assign part_prod = a_reg[MUL_A_W-1:0] * b_reg[ALU_B_W-1 -: DIGIT_W];

    always_comb
    begin
        logic [DIV_D_W:0]   r;
        logic [ALU_A_W-1:0] n;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        r         = {1'b0, rem_reg};
        n         = a_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                a_next    = req.a;
                b_next    = req.b;
                acc_next  = '0;
                rem_next  = '0;
                cnt_next  = (req.op == ALU_MUL) ? STEP_W'(MUL_STEPS - 1)
                                                : STEP_W'(DIV_STEPS - 1);
            end
        end
        else
        begin
            case (op_reg)
                ALU_MUL:
                begin
                    // most significant digit first
                    acc_next = {acc_reg[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                             + PROD_W'(part_prod);
                    b_next   = {b_reg[ALU_B_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                end
                ALU_DIV:
                begin
                    // two restoring steps; quotient bits shift into a_reg
                    for (int j = 0; j < 2; j++)
                    begin
                        r = {r[DIV_D_W-1:0], n[ALU_A_W-1]};
                        n = {n[ALU_A_W-2:0], 1'b0};
                        if (r >= {1'b0, b_reg[DIV_D_W-1:0]})
                        begin
                            r    = r - {1'b0, b_reg[DIV_D_W-1:0]};
                            n[0] = 1'b1;
                        end
                    end
                    a_next   = n;
                    rem_next = r[DIV_D_W-1:0];
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.quot = a_reg;

endmodule

// ===== design/heater_thermal_plant_step_core.sv =====
// top level: sequencer for table load, coefficient interpolation and euler step
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  command   | start / busy           | op, entry_index, entry_temp, entry_coeff,
//            |                        | power, elapsed_ms
//  result    | done (one-cycle pulse) | plate_temp, loss_coeff_used, saturated
//  config    | cfg_write              | cfg_index, cfg_data
//
//  a load transaction is answered at once; busy stays low and done follows next cycle
//  a tick transaction raises done after its accepting edge once the shared unit has
//  run three or four multiplies and one or two divides, with a segment search of
//  table reads ahead of the interpolation
//  busy is high from the cycle after a tick is taken until the cycle before done
//  reset clears control state and loads the register defaults; plate temp = room
//  the result receiver cannot stall; done lasts exactly one cycle
module heater_thermal_plant_step_core
    import htps_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic                     op,
    input  logic [2:0]               entry_index,
    input  logic [16:0]              entry_temp,
    input  logic [31:0]              entry_coeff,
    input  logic [15:0]              power,
    input  logic [15:0]              elapsed_ms,
    output logic signed [TEMP_W-1:0] plate_temp,
    output logic [31:0]              loss_coeff_used,
    output logic                     saturated,
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data
);

    // configuration registers
    logic [14:0] room_reg;
    logic [31:0] inv_reg;
    logic [31:0] dflt_reg;

    // sequencer and datapath registers
    state_t                   state_reg, state_next;
    logic signed [TEMP_W-1:0] plate_reg, plate_next;
    logic [15:0]              power_reg, power_next;
    logic [15:0]              ms_reg, ms_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [16:0]              x1_reg, x1_next;
    logic [31:0]              y1_reg, y1_next;
    logic [16:0]              den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic [31:0]              k_reg, k_next;
    logic [31:0]              loss_reg, loss_next;
    logic                     sat_reg, sat_next;
    logic                     done_reg, done_next;

    // table port
    logic                     tbl_wr;
    logic [IDX_W-1:0]         rd_idx;
    logic [16:0]              rd_temp;
    logic [31:0]              rd_coeff;
    logic [CNT_W-1:0]         count;
    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W-1:0]         prev_idx;

    // shared unit
    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;

    // compares driving the segment search
    logic signed [20:0]       x_s;
    logic signed [20:0]       rd_s;
    logic                     take;
    logic                     few_points;
    logic                     x_le_rd;
    logic                     x_ge_rd;
    logic                     x_lt_rd;

    // arithmetic intermediates
    logic signed [20:0]       dx;
    logic signed [32:0]       dy;
    logic signed [17:0]       den;
    logic [20:0]              dx_mag;
    logic [32:0]              dy_mag;
    logic [17:0]              den_mag;
    logic signed [55:0]       y1_s;
    logic signed [55:0]       quot_s;
    logic signed [55:0]       v;
    logic [31:0]              v_clamp;
    logic signed [20:0]       tr;
    logic [20:0]              tr_mag;
    logic signed [46:0]       pw_s;
    logic signed [46:0]       s_s;
    logic signed [46:0]       q;
    logic [46:0]              q_mag;
    logic signed [45:0]       dm_s;
    logic signed [45:0]       t46;
    logic signed [45:0]       nt;

    assign take       = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign tbl_wr     = take && (op == OP_LOAD);
    assign last_idx   = IDX_W'(count - CNT_W'(1));
    assign prev_idx   = IDX_W'(count - CNT_W'(2));
    assign few_points = (count < CNT_W'(2));

    assign x_s     = {plate_reg[TEMP_W-1], plate_reg};
    assign rd_s    = $signed({4'b0, rd_temp});
    assign x_le_rd = (x_s <= rd_s);
    assign x_ge_rd = (x_s >= rd_s);
    assign x_lt_rd = (x_s < rd_s);

    // segment end points: x1/y1 held, x2/y2 from the table read
    assign dx      = x_s - $signed({4'b0, x1_reg});
    assign dy      = $signed({1'b0, rd_coeff}) - $signed({1'b0, y1_reg});
    assign den     = $signed({1'b0, rd_temp}) - $signed({1'b0, x1_reg});
    assign dx_mag  = dx[20] ? 21'(-dx) : 21'(dx);
    assign dy_mag  = dy[32] ? 33'(-dy) : 33'(dy);
    assign den_mag = den[17] ? 18'(-den) : 18'(den);

    // interpolated coefficient, clamped to the unsigned 32-bit range
    assign y1_s    = $signed({24'b0, y1_reg});
    assign quot_s  = $signed({2'b0, alu_rsp.quot[53:0]});
    assign v       = neg_reg ? (y1_s - quot_s) : (y1_s + quot_s);
    assign v_clamp = v[55] ? 32'd0 : ((v[54:32] != '0) ? 32'hFFFF_FFFF : v[31:0]);

    // rise over room and net heat flow in q.16 watts
    assign tr      = x_s - $signed({6'b0, room_reg});
    assign tr_mag  = tr[20] ? 21'(-tr) : 21'(tr);
    assign pw_s    = $signed({23'b0, power_reg, 8'b0});
    assign s_s     = $signed({3'b0, alu_rsp.prod[51:8]});
    assign q       = neg_reg ? (pw_s + s_s) : (pw_s - s_s);
    assign q_mag   = q[46] ? 47'(-q) : 47'(q);

    // temperature step and new temperature before saturation
    assign dm_s    = $signed({2'b0, alu_rsp.prod[PROD_W-1:40]});
    assign t46     = $signed({{25{x_s[20]}}, x_s});
    assign nt      = neg_reg ? (t46 - dm_s) : (t46 + dm_s);

    htps_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (tbl_wr),
        .entry_index (entry_index),
        .entry_temp  (entry_temp),
        .entry_coeff (entry_coeff),
        .rd_idx      (rd_idx),
        .rd_temp     (rd_temp),
        .rd_coeff    (rd_coeff),
        .count       (count)
    );

    htps_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // table read address follows the search step
    always_comb
    begin
        case (state_reg)
            S_SRCH0: rd_idx = '0;
            S_SRCH1: rd_idx = last_idx;
            S_RDB:   rd_idx = idx_reg + IDX_W'(1);
            default: rd_idx = idx_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && (op == OP_TICK))
                begin
                    state_next = S_SRCH0;
                end
            end
            S_SRCH0:
            begin
                if (few_points)
                begin
                    state_next = S_HEAT;
                end
                else if (x_le_rd)
                begin
                    state_next = S_RDA;
                end
                else
                begin
                    state_next = S_SRCH1;
                end
            end
            S_SRCH1:
            begin
                state_next = x_ge_rd ? S_RDA : S_SCAN;
            end
            S_SCAN:
            begin
                if (x_lt_rd || (idx_reg == last_idx))
                begin
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                state_next = (rd_temp == x1_reg) ? S_HEAT : S_MUL1;
            end
            S_MUL1:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_HEAT;
                end
            end
            S_HEAT:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_MUL3;
                end
            end
            S_MUL3:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_MUL4;
                end
            end
            S_MUL4:
            begin
                if (alu_rsp.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath updates and shared unit requests
    always_comb
    begin
        plate_next    = plate_reg;
        power_next    = power_reg;
        ms_next       = ms_reg;
        idx_next      = idx_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        k_next        = k_reg;
        loss_next     = loss_reg;
        sat_next      = sat_reg;
        done_next     = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    power_next = power;
                    ms_next    = elapsed_ms;
                    if (op == OP_LOAD)
                    begin
                        // load answers at once with the unchanged temperature
                        loss_next = '0;
                        sat_next  = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end
            S_SRCH0:
            begin
                if (count == '0)
                begin
                    k_next = dflt_reg;
                end
                else if (count == CNT_W'(1))
                begin
                    k_next = rd_coeff;
                end
                else if (x_le_rd)
                begin
                    idx_next = '0;
                end
            end
            S_SRCH1:
            begin
                idx_next = x_ge_rd ? prev_idx : IDX_W'(1);
            end
            S_SCAN:
            begin
                if (x_lt_rd)
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
                else if (idx_reg == last_idx)
                begin
                    idx_next = prev_idx;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_RDA:
            begin
                x1_next = rd_temp;
                y1_next = rd_coeff;
            end
            S_RDB:
            begin
                if (rd_temp == x1_reg)
                begin
                    // flat segment keeps the left coefficient
                    k_next = y1_reg;
                end
                else
                begin
                    den_next      = den_mag[16:0];
                    neg_next      = dx[20] ^ dy[32] ^ den[17];
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_MUL;
                    alu_req.a     = ALU_A_W'(dx_mag);
                    alu_req.b     = dy_mag[31:0];
                end
            end
            S_MUL1:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_DIV;
                    alu_req.a     = ALU_A_W'(alu_rsp.prod[51:0]);
                    alu_req.b     = ALU_B_W'(den_reg);
                end
            end
            S_DIV1:
            begin
                if (alu_rsp.done)
                begin
                    k_next = v_clamp;
                end
            end
            S_HEAT:
            begin
                neg_next      = tr[20];
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = ALU_A_W'(tr_mag);
                alu_req.b     = k_reg;
            end
            S_MUL2:
            begin
                if (alu_rsp.done)
                begin
                    // sign of the energy follows the heat flow
                    neg_next      = q[46];
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_MUL;
                    alu_req.a     = ALU_A_W'(q_mag);
                    alu_req.b     = ALU_B_W'(ms_reg);
                end
            end
            S_MUL3:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_DIV;
                    alu_req.a     = alu_rsp.prod[ALU_A_W-1:0];
                    alu_req.b     = MS_PER_S;
                end
            end
            S_DIV2:
            begin
                if (alu_rsp.done)
                begin
                    alu_req.start = 1'b1;
                    alu_req.op    = ALU_MUL;
                    alu_req.a     = ALU_A_W'(alu_rsp.quot[MUL_A_W-1:0]);
                    alu_req.b     = inv_reg;
                end
            end
            S_MUL4:
            begin
                if (alu_rsp.done)
                begin
                    loss_next = k_reg;
                    done_next = 1'b1;
                    if (nt > 46'(TEMP_MAX))
                    begin
                        plate_next = TEMP_MAX;
                        sat_next   = 1'b1;
                    end
                    else if (nt < 46'(TEMP_MIN))
                    begin
                        plate_next = TEMP_MIN;
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        plate_next = nt[TEMP_W-1:0];
                        sat_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            plate_reg <= TEMP_W'(ROOM_TEMP_RST);
            room_reg  <= ROOM_TEMP_RST[14:0];
            inv_reg   <= INV_CAP_RST;
            dflt_reg  <= DFLT_LOSS_RST;
            loss_reg  <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            plate_reg <= plate_next;
            loss_reg  <= loss_next;
            sat_reg   <= sat_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ROOM_TEMP: room_reg <= cfg_data[14:0];
                    REG_INV_CAP:   inv_reg  <= cfg_data;
                    REG_DFLT_LOSS: dflt_reg <= cfg_data;
                    default:       room_reg <= room_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        power_reg <= power_next;
        ms_reg    <= ms_next;
        idx_reg   <= idx_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        k_reg     <= k_next;
    end

    assign done            = done_reg;
    assign plate_temp      = plate_reg;
    assign loss_coeff_used = loss_reg;
    assign saturated       = sat_reg;

`ifndef SYNTHESIS
    // a load answers in the next cycle with no coefficient and no clipping
    a_load_response: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (op == OP_LOAD)) |=> (done && (loss_coeff_used == '0) && !saturated))
        else $error("load transaction did not answer in the next cycle");

    // a clipped result sits on one of the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> ((plate_temp == TEMP_MAX) || (plate_temp == TEMP_MIN)))
        else $error("saturated result not at a range limit");

    // shared unit finishes only while the sequencer waits for it
    a_alu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> ((state_reg == S_MUL1) || (state_reg == S_DIV1) ||
                          (state_reg == S_MUL2) || (state_reg == S_MUL3) ||
                          (state_reg == S_DIV2) || (state_reg == S_MUL4)))
        else $error("shared unit finished outside a wait state");

    // a tick holds the block busy and gives no result in the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (op == OP_TICK)) |=> (busy && !done))
        else $error("tick transaction did not raise busy");
`endif

endmodule

// ===== bench/tb_heater_thermal_plant_step_core.sv =====
// self-checking bench for the heater thermal plant step core
`timescale 1ns / 100ps

module tb_heater_thermal_plant_step_core
    import htps_pkg::*;
();

    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  SETTLE_TICKS = 130;

    // one command transaction as driven on the ports
    typedef struct {
        logic        op;
        logic [2:0]  entry_index;
        logic [16:0] entry_temp;
        logic [31:0] entry_coeff;
        logic [15:0] power;
        logic [15:0] elapsed_ms;
    } plate_cmd_t;

    // one result transaction
    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [31:0]              coeff;
        logic                     sat;
    } plate_reading_t;

    // thermal plant predictor plus queue of readings still to come
    class plate_scoreboard;
        logic [14:0]              room;
        logic [31:0]              inv_cap;
        logic [31:0]              dflt_loss;
        logic signed [TEMP_W-1:0] plate;
        logic [16:0]              pt_temp [TABLE_POINTS];
        logic [31:0]              pt_coeff [TABLE_POINTS];
        int                       pt_count;
        int                       errors;
        plate_reading_t           expected_readings [$];

        function new();
            room      = ROOM_TEMP_RST[14:0];
            inv_cap   = INV_CAP_RST;
            dflt_loss = DFLT_LOSS_RST;
            plate     = TEMP_W'(ROOM_TEMP_RST);
            pt_count  = 0;
            errors    = 0;
            foreach (pt_temp[i])
            begin
                pt_temp[i]  = '0;
                pt_coeff[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_ROOM_TEMP)
                room = data[14:0];
            else if (idx == REG_INV_CAP)
                inv_cap = data;
            else if (idx == REG_DFLT_LOSS)
                dflt_loss = data;
        endfunction

        function longint segment(int a, int b, longint x);
            longint x1, x2, y1, y2;
            x1 = longint'(pt_temp[a]);
            x2 = longint'(pt_temp[b]);
            y1 = longint'(pt_coeff[a]);
            y2 = longint'(pt_coeff[b]);
            if (x2 == x1)
                return y1;
            return y1 + ((x - x1) * (y2 - y1)) / (x2 - x1);
        endfunction

        function logic [31:0] coeff_at(longint x);
            longint v;
            bit     found;
            int     n;
            n = pt_count;
            if (n == 0)
                return dflt_loss;
            if (n == 1)
                return pt_coeff[0];
            if (x <= longint'(pt_temp[0]))
                v = segment(0, 1, x);
            else if (x >= longint'(pt_temp[n-1]))
                v = segment(n - 2, n - 1, x);
            else
            begin
                v = segment(n - 2, n - 1, x);
                found = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (!found && x < longint'(pt_temp[i]))
                    begin
                        v = segment(i - 1, i, x);
                        found = 1;
                    end
                end
            end
            if (v < 0)
                v = 0;
            if (v > 64'hFFFF_FFFF)
                v = 64'hFFFF_FFFF;
            return v[31:0];
        endfunction

        function void note_command(plate_cmd_t c);
            plate_reading_t   r;
            longint           t, q, e, d, nt;
            longint unsigned  mag, a, b, dm;
            r.coeff = '0;
            r.sat   = 1'b0;
            if (c.op == OP_LOAD)
            begin
                pt_temp[c.entry_index]  = c.entry_temp;
                pt_coeff[c.entry_index] = c.entry_coeff;
                pt_count = int'(c.entry_index) + 1;
            end
            else
            begin
                t = longint'(plate);
                r.coeff = coeff_at(t);
                q = longint'(c.power) * 256
                    - (longint'(r.coeff) * (t - longint'(room))) / 256;
                e = (q * longint'(c.elapsed_ms)) / 1000;
                mag = (e < 0) ? longint'(-e) : longint'(e);
                a = (mag >> 20) * longint'(inv_cap);
                b = (mag & 64'hF_FFFF) * longint'(inv_cap);
                dm = (a + (b >> 20)) >> 20;
                d = (e < 0) ? -longint'(dm) : longint'(dm);
                nt = t + d;
                if (nt > longint'(TEMP_MAX))
                begin
                    nt = longint'(TEMP_MAX);
                    r.sat = 1'b1;
                end
                else if (nt < longint'(TEMP_MIN))
                begin
                    nt = longint'(TEMP_MIN);
                    r.sat = 1'b1;
                end
                plate = nt[TEMP_W-1:0];
            end
            r.temp = plate;
            expected_readings.insert(expected_readings.size(), r);
        endfunction

        function void check_result(plate_reading_t got);
            plate_reading_t want;
            if (expected_readings.size() == 0)
            begin
                $error("result with nothing expected: temp %0d", got.temp);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.temp !== want.temp)
            begin
                $error("plate_temp expected %0d actual %0d", want.temp, got.temp);
                errors++;
            end
            if (got.coeff !== want.coeff)
            begin
                $error("loss_coeff_used expected %0d actual %0d", want.coeff, got.coeff);
                errors++;
            end
            if (got.sat !== want.sat)
            begin
                $error("saturated expected %0d actual %0d", want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     done;
    logic                     op;
    logic [2:0]               entry_index;
    logic [16:0]              entry_temp;
    logic [31:0]              entry_coeff;
    logic [15:0]              power;
    logic [15:0]              elapsed_ms;
    logic signed [TEMP_W-1:0] plate_temp;
    logic [31:0]              loss_coeff_used;
    logic                     saturated;
    logic                     cfg_write;
    logic [1:0]               cfg_index;
    logic [31:0]              cfg_data;

    plate_scoreboard sb;
    int              cycles = 0;
    int              burst_left;
    // slots 0 .. filled-1 have been loaded at least once
    int              filled;

    heater_thermal_plant_step_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .op              (op),
        .entry_index     (entry_index),
        .entry_temp      (entry_temp),
        .entry_coeff     (entry_coeff),
        .power           (power),
        .elapsed_ms      (elapsed_ms),
        .plate_temp      (plate_temp),
        .loss_coeff_used (loss_coeff_used),
        .saturated       (saturated),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: the receiver never stalls, every done pulse is a transaction
    always @(posedge clk)
    begin
        plate_reading_t got;
        if (rst_n && done)
        begin
            got.temp  = plate_temp;
            got.coeff = loss_coeff_used;
            got.sat   = saturated;
            sb.check_result(got);
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_heater_thermal_plant_step_core failed");
            $finish;
        end
    end

    // present one command and hold it until start and not busy meet at an edge;
    // start stays high between commands of one burst
    task automatic send(plate_cmd_t c);
        int gap;
        op          <= c.op;
        entry_index <= c.entry_index;
        entry_temp  <= c.entry_temp;
        entry_coeff <= c.entry_coeff;
        power       <= c.power;
        elapsed_ms  <= c.elapsed_ms;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c);
        if (c.op == OP_LOAD && int'(c.entry_index) == filled)
            filled++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // a random gap, sometimes none at all
            gap = $urandom_range(0, 30);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic load_point(int idx, logic [16:0] tmp, logic [31:0] k);
        plate_cmd_t c;
        c.op          = OP_LOAD;
        c.entry_index = idx[2:0];
        c.entry_temp  = tmp;
        c.entry_coeff = k;
        c.power       = 16'($urandom);
        c.elapsed_ms  = 16'($urandom);
        send(c);
    endtask

    task automatic tick(logic [15:0] p, logic [15:0] ms);
        plate_cmd_t c;
        c.op          = OP_TICK;
        c.entry_index = 3'($urandom);
        c.entry_temp  = 17'($urandom);
        c.entry_coeff = $urandom;
        c.power       = p;
        c.elapsed_ms  = ms;
        send(c);
    endtask

    // block must be idle: drop start, drain all readings, let a tick settle
    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // one register write, with the port left idle after it
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // a table of n points, mostly ascending, sometimes shuffled or duplicated
    task automatic load_table(int n);
        logic [16:0] temps [TABLE_POINTS];
        logic [16:0] swap;
        logic [31:0] k;
        int          mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
            temps[i] = ($urandom_range(0, 3) == 0) ? 17'($urandom)
                                                   : 17'($urandom_range(0, 30000));
        if (mode < 7)
        begin
            // insertion sort for the well-formed case
            for (int i = 1; i < n; i++)
                for (int j = i; j > 0 && temps[j-1] > temps[j]; j--)
                begin
                    swap       = temps[j];
                    temps[j]   = temps[j-1];
                    temps[j-1] = swap;
                end
        end
        else if (mode == 7 && n > 1)
            temps[1] = temps[0];
        for (int i = 0; i < n; i++)
        begin
            k = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 200000);
            load_point(i, temps[i], k);
        end
    endtask

    initial
    begin
        int n;
        sb          = new();
        burst_left  = 1;
        filled      = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_LOAD;
        entry_index = '0;
        entry_temp  = '0;
        entry_coeff = '0;
        power       = '0;
        elapsed_ms  = '0;
        cfg_write   = 1'b0;
        cfg_index   = REG_ROOM_TEMP;
        cfg_data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: default coefficient, at reset values and at extremes
        tick(16'd0, 16'd0);
        tick(16'hFFFF, 16'hFFFF);
        quiesce();
        write_reg(REG_DFLT_LOSS, 32'hFFFF_FFFF);
        write_reg(REG_ROOM_TEMP, 32'h0000_7FFF);
        tick(16'd0, 16'd1000);
        quiesce();
        write_reg(REG_DFLT_LOSS, 32'd0);
        write_reg(REG_ROOM_TEMP, 32'd0);
        tick(16'd500, 16'd20);

        // single point, then a two point segment
        load_point(0, 17'd0, 32'hFFFF_FFFF);
        tick(16'd100, 16'd50);
        load_point(1, 17'h1FFFF, 32'd0);
        tick(16'd100, 16'd50);
        // equal point temperatures
        load_point(1, 17'd0, 32'd100);
        tick(16'd100, 16'd50);
        // extrapolation below zero clamps to zero
        load_point(0, 17'd1000, 32'd1000000000);
        load_point(1, 17'd2000, 32'd0);
        tick(16'd0, 16'd100);
        // extrapolation above full scale clamps
        load_point(0, 17'd1000, 32'd0);
        load_point(1, 17'd2000, 32'hFFFF_FFFF);
        tick(16'd0, 16'd100);
        // unsorted points
        load_point(0, 17'd9000, 32'd5000);
        load_point(1, 17'd3000, 32'd20000);
        load_point(2, 17'd7000, 32'd90000);
        tick(16'd2000, 16'd100);
        // shrinking back to one point with zero loss, then drive into both rails
        load_point(0, 17'd5000, 32'd0);
        quiesce();
        write_reg(REG_INV_CAP, 32'hFFFF_FFFF);
        tick(16'hFFFF, 16'hFFFF);
        load_point(0, 17'd5000, 32'hFFFF_FFFF);
        tick(16'd0, 16'hFFFF);
        tick(16'hFFFF, 16'hFFFF);
        quiesce();
        // room change leaves the plate where it is
        write_reg(REG_ROOM_TEMP, 32'hFFFF_FFFF);
        write_reg(REG_INV_CAP, 32'd0);
        load_point(0, 17'd5000, 32'd7);
        tick(16'd300, 16'd10);

        // random phases, each with its own register setting and table
        for (int ph = 0; ph < 10; ph++)
        begin
            quiesce();
            write_reg(REG_ROOM_TEMP, (ph % 3 == 0) ? $urandom : $urandom_range(4000, 9000));
            write_reg(REG_INV_CAP, (ph == 4) ? 32'hFFFF_FFFF :
                                   (ph % 2) ? $urandom : $urandom_range(10000000, 300000000));
            write_reg(REG_DFLT_LOSS, (ph == 7) ? 32'hFFFF_FFFF :
                                     (ph % 3 == 1) ? $urandom : $urandom_range(0, 60000));
            load_table($urandom_range(1, TABLE_POINTS));
            for (int i = 0; i < 115; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // rewrite a slot, possibly shrinking the table
                    n = $urandom_range(0, (filled < TABLE_POINTS) ? filled : TABLE_POINTS - 1);
                    load_point(n, 17'($urandom), $urandom);
                end
                else if ($urandom_range(0, 4) == 0)
                    tick(16'($urandom), 16'($urandom));
                else
                    tick(16'($urandom_range(0, 12000)), 16'($urandom_range(1, 200)));
            end
        end

        quiesce();
        if (sb.errors == 0)
            $display("tb_heater_thermal_plant_step_core passed");
        else
            $display("tb_heater_thermal_plant_step_core failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/htps_pkg.sv
design/htps_table.sv
design/htps_alu.sv
design/heater_thermal_plant_step_core.sv
bench/tb_heater_thermal_plant_step_core.sv
